/* hw/rtl/des_round_function_assert.svh */
// ---------------------------------------------------------------------------
// des round function assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef DES_ROUND_FUNCTION_ASSERT_SVH
`define DES_ROUND_FUNCTION_ASSERT_SVH

// same-cycle implication
`define DRF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/drf_pkg.sv */
// ---------------------------------------------------------------------------
// drf_pkg
// tables and helper functions for the des round function datapath
// ---------------------------------------------------------------------------
package drf_pkg;

	localparam int HalfW = 32;
	localparam int KeyW  = 48;

	// single substitution table shared by all eight groups, index {row, col}
	localparam logic [3:0] SboxTable [64] = '{
		4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
		4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
		4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
		4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
		4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
		4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
		4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
		4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3
	};

	// expansion table, des bit numbers (1 = msb)
	localparam logic [5:0] ExpandTable [48] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
		6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
		6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
		6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
		6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	// permutation table, des bit numbers (1 = msb)
	localparam logic [5:0] PermTable [32] = '{
		6'd16, 6'd7,  6'd20, 6'd21,
		6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26,
		6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14,
		6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,
		6'd22, 6'd11, 6'd4,  6'd25
	};

	// des bit number to vector index for a 32-bit word
	function automatic logic [4:0] des_pos32(input logic [5:0] pos);
		logic [5:0] idx;
		idx = 6'd32 - pos;
		return idx[4:0];
	endfunction

	// e expansion of a half block
	function automatic logic [KeyW-1:0] expand_half(input logic [HalfW-1:0] half);
		logic [KeyW-1:0] e;
		e = '0;
		for (int i = 0; i < KeyW; i++) begin
			e[KeyW-1-i] = half[des_pos32(ExpandTable[i])];
		end
		return e;
	endfunction

	// p permutation of the substitution word
	function automatic logic [HalfW-1:0] permute_word(input logic [HalfW-1:0] w);
		logic [HalfW-1:0] p;
		p = '0;
		for (int i = 0; i < HalfW; i++) begin
			p[HalfW-1-i] = w[des_pos32(PermTable[i])];
		end
		return p;
	endfunction

endpackage

/* hw/rtl/des_round_function.sv */
// an accepted item loads into the input register, then into the result register when the output side can take it
// throughput: one item per cycle, sustained while the output side takes results
// the f datapath between the two registers sets the clock rate
// reset: pipeline empty, apply_permutation set to 1
// ---------------------------------------------------------------------------
// des_round_function
// des round function f with shared substitution table, stream in and out
// ---------------------------------------------------------------------------
`include "des_round_function_assert.svh"

module des_round_function (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_wdata,      // apply_permutation
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,        // [31:0] right_half, [79:32] round_key
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata         // [31:0] f_result
);
	import drf_pkg::*;

	logic             apply_permutation_q;
	logic             valid_s1;
	logic [HalfW-1:0] half_s1;
	logic [KeyW-1:0]  key_s1;
	logic             valid_s2;
	logic [HalfW-1:0] result_s2;
	logic [HalfW-1:0] f_comb;
	logic             adv_s1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apply_permutation_q <= 1'b1;
		end else if (cfg_we) begin
			apply_permutation_q <= cfg_wdata;
		end
	end

	// handshake: stage moves when the next one is empty or draining
	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			half_s1 <= s_tdata[HalfW-1:0];
			key_s1  <= s_tdata[HalfW+KeyW-1:HalfW];
		end
	end

	// round function
	drf_f_core u_core (
		.right_half        (half_s1),
		.round_key         (key_s1),
		.apply_permutation (apply_permutation_q),
		.f_result          (f_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			result_s2 <= f_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	// checks
	`DRF_ASSERT_NEXT(a_load_s1, s_tvalid && s_tready, valid_s1, "accepted item not in input stage")
	`DRF_ASSERT_NEXT(a_move_s2, valid_s1 && adv_s1,
		valid_s2 && (result_s2 == $past(f_comb)), "result stage missed item")
	`DRF_ASSERT_NEXT(a_hold_s1, valid_s1 && valid_s2 && !m_tready,
		valid_s1 && $stable(half_s1) && $stable(key_s1), "blocked input stage changed")
	`DRF_ASSERT_NOW(a_full_ready, valid_s1 && valid_s2 && !m_tready, !s_tready,
		"input taken while pipeline full")

endmodule

/* hw/rtl/drf_f_core.sv */
// ---------------------------------------------------------------------------
// drf_f_core
// combinational round function: expand, key mix, substitute, optionally permute
// ---------------------------------------------------------------------------
module drf_f_core (
	input  logic [drf_pkg::HalfW-1:0] right_half,
	input  logic [drf_pkg::KeyW-1:0]  round_key,
	input  logic                      apply_permutation,
	output logic [drf_pkg::HalfW-1:0] f_result
);
	import drf_pkg::*;

	logic [KeyW-1:0]  mixed;
	logic [HalfW-1:0] sub;

	// expansion and key mix
	assign mixed = expand_half(right_half) ^ round_key;

	// eight lookups, most significant group first; row from outer bits
	always_comb begin
		logic [5:0] six;
		sub = '0;
		for (int i = 0; i < 8; i++) begin
			six = mixed[KeyW-1-6*i -: 6];
			sub[HalfW-1-4*i -: 4] = SboxTable[{six[5], six[0], six[4:1]}];
		end
	end

	// optional output permutation
	assign f_result = apply_permutation ? permute_word(sub) : sub;

endmodule
